// ----- rtl/pei_pkg.sv -----
// Package for the particle Euler integrator: widths, register indexes,
// Q0.32 coefficients, reset values and the 32-bit saturation function.
// No dependencies.
`default_nettype none

package pei_pkg;

    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int TEMP_W    = 24;
    localparam int HUM_W     = 17;
    localparam int PRES_W    = 18;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    localparam t_cfg_idx REG_GRAVITY  = 3'd0;
    localparam t_cfg_idx REG_WIND_X   = 3'd1;
    localparam t_cfg_idx REG_WIND_Y   = 3'd2;
    localparam t_cfg_idx REG_WIND_Z   = 3'd3;
    localparam t_cfg_idx REG_TEMP     = 3'd4;
    localparam t_cfg_idx REG_HUMIDITY = 3'd5;
    localparam t_cfg_idx REG_PRESSURE = 3'd6;

    localparam logic signed [26:0] C_TEMP = 27'sd42949673;
    localparam logic signed [25:0] C_HUM  = 26'sd21474836;
    localparam logic signed [16:0] C_PRES = 17'sd42950;

    localparam int TEMP_REF = 20;
    localparam logic signed [17:0] HUM_REF  = 18'sd32768;
    localparam logic signed [18:0] PRES_REF = 19'sd101325;

    localparam t_word                   GRAVITY_RST = 32'sd642908;
    localparam logic signed [TEMP_W-1:0] TEMP_RST   = 24'sd1310720;
    localparam logic [HUM_W-1:0]         HUM_RST    = 17'd32768;
    localparam logic [PRES_W-1:0]        PRES_RST   = 18'd101325;

    localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

    function automatic t_word sat32(input logic signed [67:0] x);
        if (x > SAT_HI) begin
            return 32'sh7fffffff;
        end else if (x < SAT_LO) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pei_if.sv -----
// Valid/ready channel interfaces for particle items and results.
// Depends on pei_pkg.
`default_nettype none

interface pei_in_if;
    logic                     valid;
    logic                     ready;
    pei_pkg::t_word           position_x;
    pei_pkg::t_word           position_y;
    pei_pkg::t_word           position_z;
    pei_pkg::t_word           velocity_x;
    pei_pkg::t_word           velocity_y;
    pei_pkg::t_word           velocity_z;
    logic [pei_pkg::DT_W-1:0] time_step;

    modport source (
        output valid, position_x, position_y, position_z,
        output velocity_x, velocity_y, velocity_z, time_step,
        input  ready
    );
    modport sink (
        input  valid, position_x, position_y, position_z,
        input  velocity_x, velocity_y, velocity_z, time_step,
        output ready
    );
endinterface

interface pei_out_if;
    logic           valid;
    logic           ready;
    pei_pkg::t_word new_position_x;
    pei_pkg::t_word new_position_y;
    pei_pkg::t_word new_position_z;
    pei_pkg::t_word new_velocity_x;
    pei_pkg::t_word new_velocity_y;
    pei_pkg::t_word new_velocity_z;

    modport source (
        output valid, new_position_x, new_position_y, new_position_z,
        output new_velocity_x, new_velocity_y, new_velocity_z,
        input  ready
    );
    modport sink (
        input  valid, new_position_x, new_position_y, new_position_z,
        input  new_velocity_x, new_velocity_y, new_velocity_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/particle_euler_integrator.sv -----
// Explicit Euler particle integrator: nine-stage pipeline, one transaction per cycle
// unless o_result.ready holds it back. Each stage stalls only when it holds
// an item and the stage after it cannot take one, so bubbles are squeezed out.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
// Depends on pei_pkg and pei_if.
`default_nettype none

module particle_euler_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [pei_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [pei_pkg::DATA_W-1:0]    i_cfg_data,
    pei_in_if.sink                       i_item,
    pei_out_if.source                    o_result
);

    localparam int NS      = 9;
    localparam int TD_W    = ((FRAC_BITS + 6 > pei_pkg::TEMP_W) ?
                              FRAC_BITS + 6 : pei_pkg::TEMP_W) + 1;
    localparam int TP_W    = TD_W + 27;
    localparam int DRIFT_W = TP_W - 32;
    localparam int DD_W    = DRIFT_W + 1;
    localparam int EH_W    = 28;
    localparam int M_W     = 29;
    localparam int PD_W    = 36;
    localparam int R_W     = 34;
    localparam int ACC_W   = 34;
    localparam logic signed [TD_W-1:0] TOFS = TD_W'(pei_pkg::TEMP_REF << FRAC_BITS);

    // configuration registers
    pei_pkg::t_word                     r_gravity;
    pei_pkg::t_word                     r_wind [3];
    logic signed [pei_pkg::TEMP_W-1:0]  r_temp;
    logic [pei_pkg::HUM_W-1:0]          r_hum;
    logic [pei_pkg::PRES_W-1:0]         r_pres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= pei_pkg::GRAVITY_RST;
            r_wind[0] <= '0;
            r_wind[1] <= '0;
            r_wind[2] <= '0;
            r_temp    <= pei_pkg::TEMP_RST;
            r_hum     <= pei_pkg::HUM_RST;
            r_pres    <= pei_pkg::PRES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pei_pkg::REG_GRAVITY:  r_gravity <= i_cfg_data;
                pei_pkg::REG_WIND_X:   r_wind[0] <= i_cfg_data;
                pei_pkg::REG_WIND_Y:   r_wind[1] <= i_cfg_data;
                pei_pkg::REG_WIND_Z:   r_wind[2] <= i_cfg_data;
                pei_pkg::REG_TEMP:     r_temp    <= i_cfg_data[pei_pkg::TEMP_W-1:0];
                pei_pkg::REG_HUMIDITY: r_hum     <= i_cfg_data[pei_pkg::HUM_W-1:0];
                pei_pkg::REG_PRESSURE: r_pres    <= i_cfg_data[pei_pkg::PRES_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NS:1] r_vld;
    logic [NS:1] n_vld;
    logic [NS:1] w_en;

    always_comb begin
        w_en[NS] = !r_vld[NS] || o_result.ready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = {r_vld[NS-1:1], i_item.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (w_en & n_vld) | (~w_en & r_vld);
        end
    end

    assign i_item.ready   = w_en[1];
    assign o_result.valid = r_vld[NS];

    // stage 1: acceleration and coefficient products
    pei_pkg::t_word              w_pos_in [3];
    pei_pkg::t_word              w_vel_in [3];
    logic signed [16:0]          w_dts_in;
    logic signed [32:0]          w_neg_g;
    logic signed [49:0]          w_gp;
    logic signed [47:0]          w_wp [3];
    logic signed [TD_W-1:0]      w_tdiff;
    logic signed [TP_W-1:0]      w_tp;
    logic signed [17:0]          w_hd;
    logic signed [43:0]          w_hp;
    logic signed [18:0]          w_pdiff;

    pei_pkg::t_word              r1_pos [3];
    pei_pkg::t_word              r1_vel [3];
    pei_pkg::t_word              r1_wind [3];
    logic [pei_pkg::DT_W-1:0]    r1_dt;
    logic signed [32:0]          r1_grav;
    logic signed [DRIFT_W-1:0]   r1_drift;
    logic signed [EH_W-1:0]      r1_eh;
    logic signed [PD_W-1:0]      r1_pd;

    always_comb begin
        w_pos_in[0] = i_item.position_x;
        w_pos_in[1] = i_item.position_y;
        w_pos_in[2] = i_item.position_z;
        w_vel_in[0] = i_item.velocity_x;
        w_vel_in[1] = i_item.velocity_y;
        w_vel_in[2] = i_item.velocity_z;
        w_dts_in    = $signed({1'b0, i_item.time_step});
        w_neg_g     = -(33'(r_gravity));
        w_gp        = w_neg_g * w_dts_in;
        for (int a = 0; a < 3; a++) begin
            w_wp[a] = r_wind[a] * w_dts_in;
        end
        w_tdiff = TD_W'(r_temp) - TOFS;
        w_tp    = w_tdiff * pei_pkg::C_TEMP;
        w_hd    = $signed({1'b0, r_hum}) - pei_pkg::HUM_REF;
        w_hp    = w_hd * pei_pkg::C_HUM;
        w_pdiff = $signed({1'b0, r_pres}) - pei_pkg::PRES_REF;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int a = 0; a < 3; a++) begin
                r1_pos[a]  <= w_pos_in[a];
                r1_vel[a]  <= w_vel_in[a];
                r1_wind[a] <= w_wp[a][47:16];
            end
            r1_dt    <= i_item.time_step;
            r1_grav  <= w_gp[48:16];
            r1_drift <= w_tp[TP_W-1:32];
            r1_eh    <= w_hp[43:16];
            r1_pd    <= PD_W'(w_pdiff * w_dts_in);
        end
    end

    // stage 2: velocity sums, drift, humidity and pressure terms
    logic signed [16:0]          w_dts1;
    logic signed [DRIFT_W+16:0]  w_ddp;
    logic signed [44:0]          w_qp;
    logic signed [52:0]          w_rp;

    logic signed [ACC_W-1:0]     r2_acc [3];
    pei_pkg::t_word              r2_pos [3];
    logic [pei_pkg::DT_W-1:0]    r2_dt;
    logic signed [DD_W-1:0]      r2_dd;
    logic signed [M_W-1:0]       r2_m;
    logic signed [R_W-1:0]       r2_r;

    always_comb begin
        w_dts1 = $signed({1'b0, r1_dt});
        w_ddp  = r1_drift * w_dts1;
        w_qp   = r1_eh * w_dts1;
        w_rp   = r1_pd * pei_pkg::C_PRES;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_acc[0] <= ACC_W'(r1_vel[0]) + ACC_W'(r1_wind[0]);
            r2_acc[1] <= ACC_W'(r1_vel[1]) + ACC_W'(r1_grav) + ACC_W'(r1_wind[1]);
            r2_acc[2] <= ACC_W'(r1_vel[2]) + ACC_W'(r1_wind[2]);
            r2_pos    <= r1_pos;
            r2_dt     <= r1_dt;
            r2_dd     <= w_ddp[DRIFT_W+16:16];
            r2_m      <= -(w_qp[44:16]);
            r2_r      <= R_W'(w_rp[52:16]);
        end
    end

    // stage 3: saturate the accelerated velocity
    pei_pkg::t_word              r3_v1 [3];
    pei_pkg::t_word              r3_pos [3];
    logic [pei_pkg::DT_W-1:0]    r3_dt;
    logic signed [M_W-1:0]       r3_m;
    logic signed [R_W-1:0]       r3_r;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_v1[0] <= pei_pkg::sat32(68'(r2_acc[0]) + 68'(r2_dd));
            r3_v1[1] <= pei_pkg::sat32(68'(r2_acc[1]));
            r3_v1[2] <= pei_pkg::sat32(68'(r2_acc[2]));
            r3_pos   <= r2_pos;
            r3_dt    <= r2_dt;
            r3_m     <= r2_m;
            r3_r     <= r2_r;
        end
    end

    // stage 4: humidity damping product
    logic signed [60:0]          r4_prod [3];
    pei_pkg::t_word              r4_v1 [3];
    pei_pkg::t_word              r4_pos [3];
    logic [pei_pkg::DT_W-1:0]    r4_dt;
    logic signed [R_W-1:0]       r4_r;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int a = 0; a < 3; a++) begin
                r4_prod[a] <= r3_v1[a] * r3_m;
            end
            r4_v1  <= r3_v1;
            r4_pos <= r3_pos;
            r4_dt  <= r3_dt;
            r4_r   <= r3_r;
        end
    end

    // stage 5: apply humidity factor
    pei_pkg::t_word              r5_v2 [3];
    pei_pkg::t_word              r5_pos [3];
    logic [pei_pkg::DT_W-1:0]    r5_dt;
    logic signed [R_W-1:0]       r5_r;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int a = 0; a < 3; a++) begin
                r5_v2[a] <= pei_pkg::sat32(68'(r4_v1[a]) +
                                           68'($signed(r4_prod[a][60:32])));
            end
            r5_pos <= r4_pos;
            r5_dt  <= r4_dt;
            r5_r   <= r4_r;
        end
    end

    // stage 6: pressure factor partial products
    logic signed [16:0]          w_rh;
    logic signed [17:0]          w_rl;

    logic signed [48:0]          r6_pa [3];
    logic signed [49:0]          r6_pb [3];
    pei_pkg::t_word              r6_v2 [3];
    pei_pkg::t_word              r6_pos [3];
    logic [pei_pkg::DT_W-1:0]    r6_dt;

    always_comb begin
        w_rh = r5_r[R_W-1:17];
        w_rl = $signed({1'b0, r5_r[16:0]});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int a = 0; a < 3; a++) begin
                r6_pa[a] <= r5_v2[a] * w_rh;
                r6_pb[a] <= r5_v2[a] * w_rl;
            end
            r6_v2  <= r5_v2;
            r6_pos <= r5_pos;
            r6_dt  <= r5_dt;
        end
    end

    // stage 7: apply pressure factor
    logic signed [66:0]          w_psum [3];

    pei_pkg::t_word              r7_v3 [3];
    pei_pkg::t_word              r7_pos [3];
    logic [pei_pkg::DT_W-1:0]    r7_dt;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_psum[a] = (67'(r6_pa[a]) <<< 17) + 67'(r6_pb[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            for (int a = 0; a < 3; a++) begin
                r7_v3[a] <= pei_pkg::sat32(68'(r6_v2[a]) +
                                           68'($signed(w_psum[a][66:32])));
            end
            r7_pos <= r6_pos;
            r7_dt  <= r6_dt;
        end
    end

    // stage 8: displacement product
    logic signed [16:0]          w_dts7;

    logic signed [48:0]          r8_pv [3];
    pei_pkg::t_word              r8_v3 [3];
    pei_pkg::t_word              r8_pos [3];

    assign w_dts7 = $signed({1'b0, r7_dt});

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            for (int a = 0; a < 3; a++) begin
                r8_pv[a] <= r7_v3[a] * w_dts7;
            end
            r8_v3  <= r7_v3;
            r8_pos <= r7_pos;
        end
    end

    // stage 9: advance position, output register
    pei_pkg::t_word              r9_pos [3];
    pei_pkg::t_word              r9_vel [3];

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            for (int a = 0; a < 3; a++) begin
                r9_pos[a] <= pei_pkg::sat32(68'(r8_pos[a]) +
                                            68'($signed(r8_pv[a][48:16])));
            end
            r9_vel <= r8_v3;
        end
    end

    assign o_result.new_position_x = r9_pos[0];
    assign o_result.new_position_y = r9_pos[1];
    assign o_result.new_position_z = r9_pos[2];
    assign o_result.new_velocity_x = r9_vel[0];
    assign o_result.new_velocity_y = r9_vel[1];
    assign o_result.new_velocity_z = r9_vel[2];

endmodule

`default_nettype wire
